// ===== sv/lfrr_pkg.sv =====
package lfrr_pkg;

    localparam int TABLE_DEPTH = 55;
    localparam int SHORT_LAG   = 24;
    localparam int LONG_TAP    = TABLE_DEPTH - SHORT_LAG;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 30;
    localparam int FIELD_W     = 31;
    localparam int DRAW_SHIFT  = 6;
    localparam int DRAW_W      = WORD_W - DRAW_SHIFT;
    localparam int DIFF_W      = FIELD_W + 1;

    typedef logic [WORD_W-1:0]         t_word;
    typedef logic [DRAW_W-1:0]         t_draw;
    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic [IDX_W-1:0]          t_idx;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_SPAN,
        ST_DRAW,
        ST_ADD
    } t_state;

    typedef struct packed {
        logic shift;
        logic fill;
        logic fill_first;
        logic fill_second;
    } t_chain_ctl;

endpackage

// ===== sv/lfrr_if.sv =====
interface lfrr_req_if import lfrr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field range_low;
    t_field range_high;

    modport source (output valid, output range_low, output range_high, input ready);
    modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface lfrr_rsp_if import lfrr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface lfrr_cfg_if import lfrr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

// ===== sv/lagged_fibonacci_ranged_random.sv =====
// a request word is registered and its span worked out, then draws are taken from the chain
// (one draw per cycle) until one lies in the span, or none when the span is one or less
// one request at a time: low plus the draw is registered as the result once the result register is free
// reset and every seed write start a fill of all 55 cells of the chain, no request taken meanwhile
// reset is synchronous active low: seed returns to 0, result register empties
module lagged_fibonacci_ranged_random import lfrr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfrr_cfg_if.sink    i_cfg,
    lfrr_req_if.sink    i_req,
    lfrr_rsp_if.source  o_rsp
);

    t_state     r_state, n_state;
    t_idx       r_fill_cnt, n_fill_cnt;
    t_word      r_seed, n_seed;
    t_field     r_low, n_low;
    t_field     r_high, n_high;
    logic [FIELD_W-1:0] r_span_m1, n_span_m1;
    t_draw      r_mask, n_mask;
    t_draw      r_number, n_number;
    t_field     r_value, n_value;
    logic       r_out_valid, n_out_valid;

    t_chain_ctl s_ctl;
    t_draw      w_draw;
    t_draw      w_number;
    logic signed [DIFF_W-1:0] w_diff;
    logic [FIELD_W-1:0] w_smear;
    logic       w_cfg_wr;
    logic       w_req_acc;
    logic       w_rsp_acc;

    lfrr_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (s_ctl),
        .i_seed (r_seed),
        .o_draw (w_draw)
    );

    assign w_cfg_wr  = i_cfg.valid && i_cfg.ready;
    assign w_req_acc = i_req.valid && i_req.ready;
    assign w_rsp_acc = o_rsp.valid && o_rsp.ready;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_value;

    assign w_diff   = DIFF_W'(r_high) - DIFF_W'(r_low);
    assign w_number = w_draw & r_mask;

    // all ones up to the top set bit of span - 1
    always_comb begin
        w_smear = w_diff[FIELD_W-1:0];
        w_smear = w_smear | (w_smear >> 1);
        w_smear = w_smear | (w_smear >> 2);
        w_smear = w_smear | (w_smear >> 4);
        w_smear = w_smear | (w_smear >> 8);
        w_smear = w_smear | (w_smear >> 16);
    end

    always_comb begin
        n_state     = r_state;
        n_fill_cnt  = r_fill_cnt;
        n_seed      = r_seed;
        n_low       = r_low;
        n_high      = r_high;
        n_span_m1   = r_span_m1;
        n_mask      = r_mask;
        n_number    = r_number;
        n_value     = r_value;
        n_out_valid = r_out_valid && !w_rsp_acc;
        s_ctl       = '0;

        unique case (r_state)
            ST_FILL: begin
                s_ctl.shift       = 1'b1;
                s_ctl.fill        = 1'b1;
                s_ctl.fill_first  = (r_fill_cnt == t_idx'(0));
                s_ctl.fill_second = (r_fill_cnt == t_idx'(1));
                if (r_fill_cnt == t_idx'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_fill_cnt = r_fill_cnt + t_idx'(1);
                end
            end
            ST_IDLE: begin
                if (w_req_acc) begin
                    n_low   = i_req.range_low;
                    n_high  = i_req.range_high;
                    n_state = ST_SPAN;
                end
            end
            ST_SPAN: begin
                n_span_m1 = w_diff[FIELD_W-1:0];
                n_mask    = w_smear[DRAW_W-1:0];
                n_number  = '0;
                // span of one or less, both bounds zero included: return low
                if (w_diff[DIFF_W-1] || (w_diff == '0)) begin
                    n_state = ST_ADD;
                end else begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                s_ctl.shift = 1'b1;
                if (FIELD_W'(w_number) <= r_span_m1) begin
                    n_number = w_number;
                    n_state  = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_value     = r_low + t_field'(r_number);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase

        if (w_cfg_wr) begin
            n_seed     = i_cfg.seed;
            n_fill_cnt = '0;
            n_state    = ST_FILL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fill_cnt  <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_cnt  <= n_fill_cnt;
            r_seed      <= n_seed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low     <= n_low;
        r_high    <= n_high;
        r_span_m1 <= n_span_m1;
        r_mask    <= n_mask;
        r_number  <= n_number;
        r_value   <= n_value;
    end

    a_cfg_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_state == ST_FILL) && (r_fill_cnt == '0))
        else $error("seed write did not restart the fill");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> (r_fill_cnt < t_idx'(TABLE_DEPTH)))
        else $error("fill count ran past the chain length");

    a_draw_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ADD) && ($past(r_state) == ST_DRAW))
            |-> (FIELD_W'(r_number) <= r_span_m1))
        else $error("accepted draw lies outside the span");

endmodule

// ===== sv/lfrr_cell.sv =====
module lfrr_cell import lfrr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_word i_word,
    output t_word o_word
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = i_shift ? i_word : r_word;
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== sv/lfrr_chain.sv =====
module lfrr_chain import lfrr_pkg::*; (
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  t_word      i_seed,
    output t_draw      o_draw
);

    t_word w_cell [TABLE_DEPTH];
    t_word w_next [TABLE_DEPTH];
    t_word w_sum;
    t_word w_feed;

    // cell k holds table entry write_index + k, so the lag entry sits at a fixed tap
    assign w_sum = w_cell[0] + w_cell[LONG_TAP];

    always_comb begin
        if (!i_ctl.fill) begin
            w_feed = w_sum;
        end else if (i_ctl.fill_first) begin
            w_feed = i_seed;
        end else if (i_ctl.fill_second) begin
            w_feed = t_word'(1);
        end else begin
            // fibonacci seeding from the two newest entries
            w_feed = w_cell[TABLE_DEPTH-1] + w_cell[TABLE_DEPTH-2];
        end
    end

    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
            if (k == TABLE_DEPTH - 1) begin : g_tail
                assign w_next[k] = w_feed;
            end else begin : g_body
                assign w_next[k] = w_cell[k+1];
            end
            lfrr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctl.shift),
                .i_word  (w_next[k]),
                .o_word  (w_cell[k])
            );
        end
    endgenerate

    assign o_draw = w_sum[WORD_W-1:DRAW_SHIFT];

endmodule
